// ===== hw/rtl/esmt_pkg.sv =====
// ----------------------------------------------------------------------------
// esmt_pkg
// Shared types and constants for the epoch slot table minimum tracker.
// ----------------------------------------------------------------------------
package esmt_pkg;

    // request field widths
    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 32;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 1;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_BITS    = CMD_W + SLOT_W + 2 * COUNT_W;
    localparam int OUT_BITS   = 1 + SLOT_W + 2 * COUNT_W + 1;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [COUNT_W-1:0]  THRESH_RESET = 32'd500;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER = 3'd0,
        CMD_UPDATE   = 3'd1,
        CMD_RELEASE  = 3'd2,
        CMD_QUERY    = 3'd3,
        CMD_SLOW     = 3'd4
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD = 1'b1;

endpackage

// ===== hw/rtl/esmt_ram.sv =====
// ----------------------------------------------------------------------------
// esmt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module esmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/epoch_slot_table_min_tracker.sv =====
// throughput: one request at a time; the query and free-slot scans step one slot
// per cycle through the counter RAM read port and the valid bits
// reset: all slots empty, active_slots 16, slow_threshold 500; the counter RAM
// is not cleared, and the counters of an empty slot are ignored when read
// ----------------------------------------------------------------------------
// epoch_slot_table_min_tracker
// Participant slot table for epoch-based reclamation: register, update,
// release, minimum query and slow check over a RAM of recorded counters.
// ----------------------------------------------------------------------------
module epoch_slot_table_min_tracker #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command [2:0], slot [6:3], global_count [38:7], global_seg_count [70:39]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [esmt_pkg::IN_DATA_W-1:0]    s_tdata,
    // status [0], assigned_slot [4:1], min_count [36:5], min_seg_count [68:37],
    // is_slow [69]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [esmt_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [esmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [esmt_pkg::COUNT_W-1:0]      cfg_data
);

    import esmt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_FREE,
        ST_SCAN_MIN,
        ST_SLOW_CMP,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [COUNT_W-1:0]     gc_reg, gc_next;
    logic [COUNT_W-1:0]     gsc_reg, gsc_next;
    logic [ACTIVE_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]     min_c_reg, min_c_next;
    logic [COUNT_W-1:0]     min_s_reg, min_s_next;
    logic                   any_reg, any_next;
    logic                   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0]     res_min_reg, res_min_next;
    logic [COUNT_W-1:0]     res_min_seg_reg, res_min_seg_next;
    logic                   res_slow_reg, res_slow_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic [ACTIVE_W-1:0]    active_reg, active_next;
    logic [COUNT_W-1:0]     thresh_reg, thresh_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;

    logic [ACTIVE_W-1:0]    eff_slots;
    logic                   slot_occ;
    logic [ACTIVE_W-1:0]    idx_inc;
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [2*COUNT_W-1:0]   ram_wdata;
    logic                   ram_re;
    logic [IW-1:0]          ram_raddr;
    logic [2*COUNT_W-1:0]   ram_rdata;
    logic [COUNT_W-1:0]     rd_count;
    logic [COUNT_W-1:0]     rd_seg_count;
    logic                   row_valid;
    logic [COUNT_W-1:0]     cur_min_c;
    logic [COUNT_W-1:0]     cur_min_s;
    logic [COUNT_W-1:0]     lag;

    // counters of each slot, segment counter in the upper half
    esmt_ram #(
        .WIDTH (2 * COUNT_W),
        .DEPTH (SLOTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // active_slots saturates at the table size
    assign eff_slots = ({{(32 - ACTIVE_W){1'b0}}, active_reg} > 32'(SLOTS)) ?
                       ACTIVE_W'(SLOTS) : active_reg;
    assign slot_occ  = ({1'b0, slot_reg} < eff_slots) && valid_reg[IW'(slot_reg)];
    assign idx_inc   = idx_reg + ACTIVE_W'(1);

    assign rd_count     = ram_rdata[COUNT_W-1:0];
    assign rd_seg_count = ram_rdata[2*COUNT_W-1:COUNT_W];
    assign row_valid    = valid_reg[IW'(idx_reg)];
    assign cur_min_c    = (row_valid && (!any_reg || rd_count < min_c_reg)) ?
                          rd_count : min_c_reg;
    assign cur_min_s    = (row_valid && (!any_reg || rd_seg_count < min_s_reg)) ?
                          rd_seg_count : min_s_reg;
    assign lag          = gc_reg - rd_count;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        slot_next        = slot_reg;
        gc_next          = gc_reg;
        gsc_next         = gsc_reg;
        idx_next         = idx_reg;
        min_c_next       = min_c_reg;
        min_s_next       = min_s_reg;
        any_next         = any_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_min_next     = res_min_reg;
        res_min_seg_next = res_min_seg_reg;
        res_slow_next    = res_slow_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        active_next      = active_reg;
        thresh_next      = thresh_reg;
        valid_next       = valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = IW'(slot_reg);
        ram_wdata        = {gsc_reg, gc_reg};
        ram_re           = 1'b0;
        ram_raddr        = IW'(idx_inc);

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIVE_SLOTS:   active_next = cfg_data[ACTIVE_W-1:0];
                CFG_SLOW_THRESHOLD: thresh_next = cfg_data;
                default:            ;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tdata[CMD_W-1:0]);
                    slot_next  = s_tdata[CMD_W +: SLOT_W];
                    gc_next    = s_tdata[CMD_W + SLOT_W +: COUNT_W];
                    gsc_next   = s_tdata[CMD_W + SLOT_W + COUNT_W +: COUNT_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_status_next  = 1'b0;
                res_slot_next    = '0;
                res_min_next     = '0;
                res_min_seg_next = '0;
                res_slow_next    = 1'b0;
                idx_next         = '0;
                state_next       = ST_DONE;
                case (cmd_reg)
                    CMD_UPDATE:
                    begin
                        if (slot_occ)
                        begin
                            ram_we        = 1'b1;
                            res_slot_next = slot_reg;
                        end
                        else
                        begin
                            // unoccupied slot falls back to register
                            state_next = ST_SCAN_FREE;
                        end
                    end
                    CMD_REGISTER:
                    begin
                        state_next = ST_SCAN_FREE;
                    end
                    CMD_RELEASE:
                    begin
                        if (slot_occ)
                        begin
                            valid_next[IW'(slot_reg)] = 1'b0;
                        end
                    end
                    CMD_QUERY:
                    begin
                        min_c_next = gc_reg;
                        min_s_next = gsc_reg;
                        any_next   = 1'b0;
                        if (eff_slots == '0)
                        begin
                            res_min_next     = gc_reg;
                            res_min_seg_next = gsc_reg;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = ST_SCAN_MIN;
                        end
                    end
                    CMD_SLOW:
                    begin
                        if (slot_occ)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = IW'(slot_reg);
                            state_next = ST_SLOW_CMP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN_FREE:
            begin
                if (idx_reg == eff_slots)
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (!row_valid)
                begin
                    valid_next[IW'(idx_reg)] = 1'b1;
                    ram_we        = 1'b1;
                    ram_waddr     = IW'(idx_reg);
                    res_slot_next = SLOT_W'(idx_reg);
                    state_next    = ST_DONE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_SCAN_MIN:
            begin
                // read data of row idx is on the RAM output this cycle
                if (idx_inc == eff_slots)
                begin
                    res_min_next     = cur_min_c;
                    res_min_seg_next = cur_min_s;
                    state_next       = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    idx_next   = idx_inc;
                    min_c_next = cur_min_c;
                    min_s_next = cur_min_s;
                    any_next   = any_reg | row_valid;
                end
            end
            ST_SLOW_CMP:
            begin
                res_slow_next = (lag > thresh_reg);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_W'({res_slow_reg, res_min_seg_reg,
                                                  res_min_reg, res_slot_reg,
                                                  res_status_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= CMD_REGISTER;
            slot_reg        <= '0;
            gc_reg          <= '0;
            gsc_reg         <= '0;
            idx_reg         <= '0;
            min_c_reg       <= '0;
            min_s_reg       <= '0;
            any_reg         <= 1'b0;
            res_status_reg  <= 1'b0;
            res_slot_reg    <= '0;
            res_min_reg     <= '0;
            res_min_seg_reg <= '0;
            res_slow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            active_reg      <= ACTIVE_RESET;
            thresh_reg      <= THRESH_RESET;
            valid_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            slot_reg        <= slot_next;
            gc_reg          <= gc_next;
            gsc_reg         <= gsc_next;
            idx_reg         <= idx_next;
            min_c_reg       <= min_c_next;
            min_s_reg       <= min_s_next;
            any_reg         <= any_next;
            res_status_reg  <= res_status_next;
            res_slot_reg    <= res_slot_next;
            res_min_reg     <= res_min_next;
            res_min_seg_reg <= res_min_seg_next;
            res_slow_reg    <= res_slow_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            active_reg      <= active_next;
            thresh_reg      <= thresh_next;
            valid_reg       <= valid_next;
        end
    end

endmodule

// ===== hw/rtl/esmt_checker.sv =====
// ----------------------------------------------------------------------------
// esmt_checker
// Port-level checks on the slot table: request spacing and result encoding.
// ----------------------------------------------------------------------------
module esmt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [esmt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import esmt_pkg::*;

    // one request at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // full table reports slot zero
    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[4:1] == '0 && m_tdata[69] == 1'b0)
        else $error("full status with a slot or slow flag");

    // slow flag comes only from check slow, all other fields zero
    a_slow_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[69] |-> m_tdata[68:0] == '0)
        else $error("slow flag mixed with other results");

    // padding stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_BITS] == '0)
        else $error("result padding not zero");

endmodule

bind epoch_slot_table_min_tracker esmt_checker u_esmt_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the epoch slot table minimum tracker. A short
// directed walk covers empty-table answers, implicit register, slow-check
// boundaries, wrap-around lag and unknown commands. Randomised phases follow,
// each under its own slot count and threshold, with both stream sides idling
// at random. Results are checked against a behavioural table copy or a directed answer.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import esmt_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 90;
    localparam int WATCHDOG     = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP    = 50;
    localparam int DIR_N        = 22;

    // command codes the block does not know
    localparam logic [CMD_W-1:0] CMD_BAD_LO = CMD_SLOW + 3'd1;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = '1;

    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] gcount;
        logic [COUNT_W-1:0] gseg;
    } request_t;

    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] min_cnt;
        logic [COUNT_W-1:0] min_seg;
        logic               slow;
    } answer_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        answer_t  want;
    } dir_row_t;

    localparam answer_t NIL = '0;

    // rows with typed answers rely on the reset values of the registers
    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{'{CMD_QUERY,    4'd0,  32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
        '{'{CMD_SLOW,     4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, NIL},
        '{'{CMD_RELEASE,  4'd15, 32'h0000_0000, 32'h0000_0000}, 1'b1, NIL},
        '{'{CMD_UPDATE,   4'd7,  32'd10,        32'd20       }, 1'b1, NIL},
        '{'{CMD_REGISTER, 4'd0,  32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 4'd1, 32'd0, 32'd0, 1'b0}},
        '{'{CMD_REGISTER, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
          '{1'b0, 4'd2, 32'd0, 32'd0, 1'b0}},
        '{'{CMD_QUERY,    4'd0,  32'd5,         32'd5        }, 1'b0, NIL},
        '{'{CMD_UPDATE,   4'd1,  32'd1000,      32'd7        }, 1'b0, NIL},
        '{'{CMD_SLOW,     4'd1,  32'd1500,      32'd0        }, 1'b0, NIL},
        '{'{CMD_SLOW,     4'd1,  32'd1501,      32'd0        }, 1'b0, NIL},
        '{'{CMD_SLOW,     4'd2,  32'd0,         32'd0        }, 1'b0, NIL},
        '{'{CMD_SLOW,     4'd0,  32'd9,         32'd0        }, 1'b0, NIL},
        '{'{CMD_RELEASE,  4'd1,  32'd0,         32'd0        }, 1'b0, NIL},
        '{'{CMD_QUERY,    4'd3,  32'd3,         32'd3        }, 1'b0, NIL},
        '{'{CMD_REGISTER, 4'd9,  32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, NIL},
        '{'{CMD_RELEASE,  4'd0,  32'd0,         32'd0        }, 1'b0, NIL},
        '{'{CMD_UPDATE,   4'd0,  32'd42,        32'd43       }, 1'b0, NIL},
        '{'{CMD_BAD_HI,   4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, NIL},
        '{'{CMD_BAD_LO,   4'd0,  32'd0,         32'd0        }, 1'b1, NIL},
        '{'{CMD_QUERY,    4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NIL},
        '{'{CMD_SLOW,     4'd3,  32'hFFFF_FFFF, 32'd0        }, 1'b0, NIL},
        '{'{CMD_QUERY,    4'd8,  32'h8000_0000, 32'h0000_0001}, 1'b0, NIL}
    };

    localparam logic [ACTIVE_W-1:0] PHASE_ACTIVE [PHASES] = '{
        5'd1, 5'd0, 5'd16, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2, 5'd16, 5'd5
    };
    localparam logic [COUNT_W-1:0] PHASE_THRESH [PHASES] = '{
        32'd0, 32'hFFFF_FFFF, 32'd1, 32'd500, 32'd1000,
        32'h7FFF_FFFF, 32'd250, 32'd2, 32'd64, 32'hFFFF_FFFE
    };

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [COUNT_W-1:0]      cfg_data;

    // behavioural copy of the slot table
    logic [NUM_SLOTS-1:0]    slot_busy;
    logic [COUNT_W-1:0]      slot_cnt [NUM_SLOTS];
    logic [COUNT_W-1:0]      slot_seg [NUM_SLOTS];
    logic [ACTIVE_W-1:0]     active_cfg;
    logic [COUNT_W-1:0]      thresh_cfg;

    answer_t                 pending_q [$];
    int                      mismatches;
    int                      stall_cycles;
    bit                      gaps_on;
    logic [COUNT_W-1:0]      epoch_cnt;
    logic [COUNT_W-1:0]      epoch_seg;

    epoch_slot_table_min_tracker #(
        .SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned usable_slots();
        return (active_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(active_cfg);
    endfunction

    function automatic bit holds(logic [SLOT_W-1:0] s);
        return (s < usable_slots()) && slot_busy[s];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // advances the table copy by one request and returns its answer
    function automatic answer_t apply_request(request_t r);
        answer_t            a;
        int unsigned        lim;
        bit                 found;
        logic [COUNT_W-1:0] lag;
        a     = '0;
        lim   = usable_slots();
        found = 1'b0;
        case (r.op)
            CMD_REGISTER, CMD_UPDATE:
            begin
                if (r.op == CMD_UPDATE && holds(r.slot))
                begin
                    slot_cnt[r.slot] = r.gcount;
                    slot_seg[r.slot] = r.gseg;
                    a.slot           = r.slot;
                end
                else
                begin
                    // update of an empty slot falls back to register
                    for (int i = 0; i < lim; i++)
                    begin
                        if (!found && !slot_busy[i])
                        begin
                            slot_busy[i] = 1'b1;
                            slot_cnt[i]  = r.gcount;
                            slot_seg[i]  = r.gseg;
                            a.slot       = SLOT_W'(i);
                            found        = 1'b1;
                        end
                    end
                    a.status = !found;
                end
            end
            CMD_RELEASE:
            begin
                if (holds(r.slot))
                    slot_busy[r.slot] = 1'b0;
            end
            CMD_QUERY:
            begin
                a.min_cnt = r.gcount;
                a.min_seg = r.gseg;
                for (int i = 0; i < lim; i++)
                begin
                    if (slot_busy[i])
                    begin
                        if (!found || slot_cnt[i] < a.min_cnt)
                            a.min_cnt = slot_cnt[i];
                        if (!found || slot_seg[i] < a.min_seg)
                            a.min_seg = slot_seg[i];
                        found = 1'b1;
                    end
                end
            end
            CMD_SLOW:
            begin
                lag    = r.gcount - slot_cnt[r.slot];
                a.slow = holds(r.slot) && (lag > thresh_cfg);
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    // counters creep forward so that lags stay near the threshold
    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        int unsigned lim;
        lim       = usable_slots();
        epoch_cnt = epoch_cnt + $urandom_range(0, 400);
        epoch_seg = epoch_seg + $urandom_range(0, 400);
        r.gcount  = epoch_cnt;
        r.gseg    = epoch_seg;
        if ($urandom_range(0, 9) == 0)
        begin
            r.gcount = $urandom;
            r.gseg   = $urandom;
        end
        if (lim != 0 && $urandom_range(0, 9) < 7)
            r.slot = SLOT_W'($urandom_range(0, lim - 1));
        else
            r.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            r.op = CMD_REGISTER;
        else if (pick < 45)
            r.op = CMD_UPDATE;
        else if (pick < 60)
            r.op = CMD_RELEASE;
        else if (pick < 78)
            r.op = CMD_QUERY;
        else if (pick < 95)
            r.op = CMD_SLOW;
        else
            r.op = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        // land right on the threshold edge half the time
        if (r.op == CMD_SLOW && $urandom_range(0, 1) == 1)
            r.gcount = slot_cnt[r.slot] + thresh_cfg + $urandom_range(0, 2) - 1;
        return r;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic issue(request_t r, bit typed, answer_t want, bit last);
        answer_t     predicted;
        int unsigned g;
        s_tdata  <= IN_DATA_W'({r.gseg, r.gcount, r.slot, r.op});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(r);
        pending_q.push_back(typed ? want : predicted);
        g = idle_len();
        if (last || g != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic configure(logic [ACTIVE_W-1:0] n, logic [COUNT_W-1:0] th);
        cfg_index <= CFG_ACTIVE_SLOTS;
        cfg_data  <= COUNT_W'(n);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        active_cfg = n;
        cfg_index <= CFG_SLOW_THRESHOLD;
        cfg_data  <= th;
        do
            @(posedge clk);
        while (!cfg_ready);
        thresh_cfg = th;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0);
    endtask

    task automatic check_answer();
        answer_t got;
        answer_t exp;
        got.status  = m_tdata[0];
        got.slot    = m_tdata[4:1];
        got.min_cnt = m_tdata[36:5];
        got.min_seg = m_tdata[68:37];
        got.slow    = m_tdata[69];
        if (pending_q.size() == 0)
        begin
            report("result with no request outstanding");
            return;
        end
        exp = pending_q.pop_front();
        if (got.status !== exp.status)
            report($sformatf("status got %0b expected %0b", got.status, exp.status));
        if (got.slot !== exp.slot)
            report($sformatf("assigned_slot got %0d expected %0d", got.slot, exp.slot));
        if (got.min_cnt !== exp.min_cnt)
            report($sformatf("min_count got %h expected %h", got.min_cnt, exp.min_cnt));
        if (got.min_seg !== exp.min_seg)
            report($sformatf("min_seg_count got %h expected %h", got.min_seg, exp.min_seg));
        if (got.slow !== exp.slow)
            report($sformatf("is_slow got %0b expected %0b", got.slow, exp.slow));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_answer();
    end

    // result side back-pressure
    initial
    begin
        int unsigned g;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            g = idle_len();
            if (g != 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_ACTIVE_SLOTS;
        cfg_data     = '0;
        mismatches   = 0;
        stall_cycles = 0;
        gaps_on      = 1'b1;
        epoch_cnt    = '0;
        epoch_seg    = '0;
        slot_busy    = '0;
        active_cfg   = ACTIVE_RESET;
        thresh_cfg   = THRESH_RESET;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_cnt[i] = '0;
            slot_seg[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++)
            issue(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].want, k == DIR_N - 1);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            configure(PHASE_ACTIVE[p], PHASE_THRESH[p]);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                issue(random_request(), 1'b0, NIL, k == PHASE_ITEMS - 1);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
